FILE: rtl/tfpd_pkg.sv
// tfpd_pkg: constants, register indexes and shared types of the PD steering block.
// No dependencies; imported by tfpd_div and tape_follow_pd_steering_top.
`timescale 1ns / 1ps
`default_nettype none

package tfpd_pkg;

	// Field widths
	localparam int GAIN_W  = 7;
	localparam int LOST_W  = 4;
	localparam int BASE_W  = 12;
	localparam int ERR_W   = 5;
	localparam int DIFF_W  = 6;
	localparam int MAG_W   = 5;
	localparam int TIME_W  = 32;
	localparam int DERIV_W = 22;
	localparam int TERM_W  = 29;
	localparam int PTERM_W = GAIN_W + ERR_W;

	// Divider sizing: |100000 * 20| < 2^21
	localparam int NUM_W = 21;
	localparam int DEN_W = TIME_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam int SCALE_W = 17;
	localparam logic [SCALE_W-1:0] DERIV_SCALE = 17'd100000;
	localparam logic [LOST_W-1:0]  LOST_MAX    = 4'd10;

	// Configuration register indexes
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DERIV = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LOST_ERROR = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_LEFT  = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BASE_RIGHT = 3'd4;

	// Divider status back to the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

FILE: rtl/tfpd_div.sv
// tfpd_div: restoring unsigned divider, one quotient bit per cycle.
// Depends on tfpd_pkg (widths, div_stat_t).
`timescale 1ns / 1ps
`default_nettype none

module tfpd_div (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic [tfpd_pkg::NUM_W-1:0] num,
	input  wire logic [tfpd_pkg::DEN_W-1:0] den,
	output logic      [tfpd_pkg::NUM_W-1:0] quo,
	output tfpd_pkg::div_stat_t           stat
);
	import tfpd_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] nq_q;   // numerator bits shift out, quotient bits shift in

	logic [DEN_W:0] trial;
	logic [DEN_W:0] trial_sub;
	logic           ge;

	assign trial     = {rem_q, nq_q[NUM_W-1]};
	assign trial_sub = trial - {1'b0, den_q};
	assign ge        = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
			nq_q  <= {nq_q[NUM_W-2:0], ge};
		end
	end

	assign quo       = nq_q;
	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

FILE: rtl/tape_follow_pd_steering_top.sv
// tape_follow_pd_steering_top: PD steering from two tape sensors and a timestamp.
// Depends on tfpd_pkg and tfpd_div (iterative divider).
//
//  channel | handshake               | beat payload
//  --------+-------------------------+-----------------------------------------------
//  in      | in_valid / in_ready     | left_on_tape, right_on_tape, time_us
//  out     | out_valid / out_ready   | error_value, derivative_value, control_term,
//          |                         | left_drive, right_drive
//  cfg     | cfg_valid / cfg_ready   | cfg_addr (register index), cfg_data
//
// After accept, a beat passes through the scale state, the divider's quotient steps
// and its done flag, then one state each for the two gain products and the drive
// sums; the drive-sum state waits until the result register is free.
// in_ready is high only while the sequencer is idle; the result register lets the
// next beat start while a result still waits for out_ready.
// cfg_ready is always high. Async reset loads register defaults and clears history.
`timescale 1ns / 1ps
`default_nettype none

module tape_follow_pd_steering_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            left_on_tape,
	input  wire logic                            right_on_tape,
	input  wire logic [tfpd_pkg::TIME_W-1:0]     time_us,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [tfpd_pkg::ERR_W-1:0]    error_value,
	output logic signed [tfpd_pkg::DERIV_W-1:0]  derivative_value,
	output logic signed [tfpd_pkg::TERM_W-1:0]   control_term,
	output logic signed [tfpd_pkg::TERM_W-1:0]   left_drive,
	output logic signed [tfpd_pkg::TERM_W-1:0]   right_drive,
	// configuration channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [tfpd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [tfpd_pkg::BASE_W-1:0]     cfg_data
);
	import tfpd_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCALE = 3'd1;  // start divider on scaled error change
	localparam logic [2:0] S_DIV   = 3'd2;  // wait for quotient
	localparam logic [2:0] S_DMUL  = 3'd3;  // gain_deriv * derivative
	localparam logic [2:0] S_PMUL  = 3'd4;  // gain_prop * error, form term
	localparam logic [2:0] S_TERM  = 3'd5;  // drive sums into result register

	logic [2:0] state_q;

	// configuration registers
	logic [GAIN_W-1:0] gain_prop_q;
	logic [GAIN_W-1:0] gain_deriv_q;
	logic [LOST_W-1:0] lost_error_q;
	logic [BASE_W-1:0] base_left_q;
	logic [BASE_W-1:0] base_right_q;

	// history
	logic signed [ERR_W-1:0] last_err_q;
	logic                    left_of_tape_q;
	logic [TIME_W-1:0]       last_time_q;

	// per-beat working registers
	logic signed [ERR_W-1:0]   err_q;
	logic [MAG_W-1:0]          mag_q;
	logic                      neg_q;
	logic                      zero_q;
	logic [TIME_W-1:0]         dt_q;
	logic signed [DERIV_W-1:0] deriv_q;
	logic signed [TERM_W-1:0]  dprod_q;
	logic signed [TERM_W-1:0]  term_q;

	// result register
	logic                      out_valid_q;
	logic signed [ERR_W-1:0]   err_out_q;
	logic signed [DERIV_W-1:0] deriv_out_q;
	logic signed [TERM_W-1:0]  term_out_q;
	logic signed [TERM_W-1:0]  left_out_q;
	logic signed [TERM_W-1:0]  right_out_q;

	// combinational
	logic                      in_fire;
	logic                      out_free;
	logic [LOST_W-1:0]         lost_c;
	logic signed [ERR_W-1:0]   err_c;
	logic                      lot_c;
	logic [TIME_W-1:0]         dt_c;
	logic signed [DIFF_W-1:0]  diff_c;
	logic [DIFF_W-1:0]         diff_abs_c;
	logic [NUM_W-1:0]          scaled_c;
	logic [NUM_W-1:0]          div_quo;
	div_stat_t                 div_st;
	logic                      div_start;
	logic signed [DERIV_W-1:0] quo_ext;
	logic signed [TERM_W:0]    dprod_full;
	logic signed [PTERM_W-1:0] pterm_c;
	logic signed [TERM_W:0]    left_full;
	logic signed [TERM_W:0]    right_full;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// steering error and remembered side
	assign lost_c = (lost_error_q > LOST_MAX) ? LOST_MAX : lost_error_q;

	always_comb begin
		lot_c = left_of_tape_q;
		case ({left_on_tape, right_on_tape})
			2'b11: begin
				err_c = '0;
				lot_c = 1'b1;
			end
			2'b10: begin
				err_c = ERR_W'(1);
				lot_c = 1'b0;
			end
			2'b01: begin
				err_c = -ERR_W'(1);
				lot_c = 1'b1;
			end
			default: begin
				err_c = left_of_tape_q ? -ERR_W'(lost_c) : ERR_W'(lost_c);
			end
		endcase
	end

	// elapsed time wraps modulo 2^32
	assign dt_c       = time_us - last_time_q;
	assign diff_c     = DIFF_W'(err_c) - DIFF_W'(last_err_q);
	assign diff_abs_c = diff_c[DIFF_W-1] ? -diff_c : diff_c;

	// 100000 * |change|, fits NUM_W bits
	assign scaled_c  = NUM_W'(DERIV_SCALE) * NUM_W'(mag_q);
	assign div_start = (state_q == S_SCALE);

	tfpd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (scaled_c),
		.den    (dt_q),
		.quo    (div_quo),
		.stat   (div_st)
	);

	assign quo_ext    = DERIV_W'(div_quo);
	assign dprod_full = $signed({1'b0, gain_deriv_q}) * deriv_q;
	assign pterm_c    = $signed({1'b0, gain_prop_q}) * err_q;
	assign left_full  = $signed({1'b0, (TERM_W)'(base_left_q)}) - (TERM_W + 1)'(term_q);
	assign right_full = $signed({1'b0, (TERM_W)'(base_right_q)}) + (TERM_W + 1)'(term_q);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= GAIN_W'(10);
			gain_deriv_q <= GAIN_W'(1);
			lost_error_q <= LOST_W'(3);
			base_left_q  <= BASE_W'(1000);
			base_right_q <= BASE_W'(700);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				REG_GAIN_PROP:  gain_prop_q  <= cfg_data[GAIN_W-1:0];
				REG_GAIN_DERIV: gain_deriv_q <= cfg_data[GAIN_W-1:0];
				REG_LOST_ERROR: lost_error_q <= cfg_data[LOST_W-1:0];
				REG_BASE_LEFT:  base_left_q  <= cfg_data;
				REG_BASE_RIGHT: base_right_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			last_err_q     <= '0;
			left_of_tape_q <= 1'b0;
			last_time_q    <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			// a new result replaces a taken one in the same cycle
			if (state_q == S_TERM && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						last_err_q     <= err_c;
						left_of_tape_q <= lot_c;
						last_time_q    <= time_us;
						state_q        <= S_SCALE;
					end
				end
				S_SCALE: state_q <= S_DIV;
				S_DIV: begin
					if (div_st.done) begin
						state_q <= S_DMUL;
					end
				end
				S_DMUL: state_q <= S_PMUL;
				S_PMUL: state_q <= S_TERM;
				S_TERM: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q  <= err_c;
			neg_q  <= diff_c[DIFF_W-1];
			mag_q  <= diff_abs_c[MAG_W-1:0];
			zero_q <= (diff_c == '0) || (dt_c == '0);
			dt_q   <= dt_c;
		end
		if (state_q == S_DIV && div_st.done) begin
			// no change or no elapsed time gives zero, else apply sign
			deriv_q <= zero_q ? '0 : (neg_q ? -quo_ext : quo_ext);
		end
		if (state_q == S_DMUL) begin
			dprod_q <= dprod_full[TERM_W-1:0];
		end
		if (state_q == S_PMUL) begin
			term_q <= TERM_W'(pterm_c) - dprod_q;
		end
		if (state_q == S_TERM && out_free) begin
			err_out_q   <= err_q;
			deriv_out_q <= deriv_q;
			term_out_q  <= term_q;
			left_out_q  <= left_full[TERM_W-1:0];
			right_out_q <= right_full[TERM_W-1:0];
		end
	end

	assign out_valid        = out_valid_q;
	assign error_value      = err_out_q;
	assign derivative_value = deriv_out_q;
	assign control_term     = term_out_q;
	assign left_drive       = left_out_q;
	assign right_drive      = right_out_q;

	// quotient arrives only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == S_DIV))
		else $error("divider done outside divide state");

	// divider is idle whenever a new beat can be taken
	a_div_idle_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> !div_st.busy)
		else $error("beat accepted while divider busy");

	// a finished beat waits rather than overwrite an untaken result
	a_term_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TERM && out_valid_q && !out_ready) |=> (state_q == S_TERM))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire
